// ===== sv/led_seq_pkg.sv =====
// ----------------------------------------------------------------------------
// led_seq_pkg
// shared constants, codes, reset tables and controller/datapath bundles
// ----------------------------------------------------------------------------
package led_seq_pkg;

   localparam int MODE_COUNT     = 8;
   localparam int STEPS_PER_MODE = 8;

   localparam int MODE_W   = $clog2(MODE_COUNT);
   localparam int STEP_W   = (STEPS_PER_MODE > 1) ? $clog2(STEPS_PER_MODE) : 1;
   localparam int ENTRY_W  = 4;
   localparam int ROW_W    = STEPS_PER_MODE * ENTRY_W;
   localparam int HOLD_W   = 10;
   localparam int MASK_W   = 3;

   localparam int FIRST_SLOT       = 4;
   localparam int INIT_MODES       = 4;
   localparam int PERIOD_UNIT      = 100;
   localparam int MAX_DIGIT        = 9;
   localparam int MAX_DEFINE_STEPS = 8;
   localparam int DEFAULT_PERIOD   = 500;
   localparam int RESET_HOLD       = 400;
   localparam logic [MASK_W-1:0] RESET_MASK = 3'h1;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_BUTTON = 2'd1,
      ACT_SELECT = 2'd2,
      ACT_DEFINE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      REPLY_NONE   = 2'd0,
      REPLY_OK     = 2'd1,
      REPLY_REJECT = 2'd2
   } reply_type;

   typedef logic [HOLD_W-1:0] period_array_type [8];
   typedef logic [MASK_W-1:0] pattern_array_type [INIT_MODES][4];

   localparam period_array_type PERIOD_INIT = '{
      10'd400, 10'd400, 10'd1000, 10'd100, 10'd500, 10'd500, 10'd500, 10'd500
   };

   localparam pattern_array_type PATTERN_INIT = '{
      '{3'h1, 3'h2, 3'h1, 3'h2},
      '{3'h3, 3'h0, 3'h3, 3'h0},
      '{3'h1, 3'h2, 3'h4, 3'h0},
      '{3'h2, 3'h4, 3'h2, 3'h4}
   };

   typedef struct packed {
      logic accept;
      logic tick_dec;
      logic tick_adv;
      logic next_mode;
      logic select;
      logic define;
      logic check;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       expire;
      logic       found;
   } stat_type;

   // row of a mode as it stands after reset
   function automatic logic [ROW_W-1:0] init_row(input logic [MODE_W-1:0] mode);
      logic [ROW_W-1:0] row;
      row = '0;
      for (int s = 0; s < STEPS_PER_MODE; s++) begin
         if (mode < MODE_W'(INIT_MODES) && s < 4) begin
            row[s*ENTRY_W +: ENTRY_W] = {1'b1, PATTERN_INIT[mode[1:0]][s[1:0]]};
         end
      end
      return row;
   endfunction

   function automatic logic [HOLD_W-1:0] init_period(input int mode);
      logic [HOLD_W-1:0] p;
      if (mode < 8) begin
         p = PERIOD_INIT[mode[2:0]];
      end else begin
         p = HOLD_W'(DEFAULT_PERIOD);
      end
      return p;
   endfunction

endpackage

// ===== sv/led_seq_ram.sv =====
// ----------------------------------------------------------------------------
// led_seq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module led_seq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/led_seq_ctrl.sv =====
// ----------------------------------------------------------------------------
// led_seq_ctrl
// sequencing of one word: command dispatch, mode walk, result handoff
// ----------------------------------------------------------------------------
module led_seq_ctrl
   import led_seq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_FINISH;
               case (stat.action)
                  ACT_TICK: begin
                     if (stat.expire) begin
                        cmd.tick_adv = 1'b1;
                        state_in     = ST_READ;
                     end else begin
                        cmd.tick_dec = 1'b1;
                     end
                  end
                  ACT_BUTTON: begin
                     cmd.next_mode = 1'b1;
                     state_in      = ST_READ;
                  end
                  ACT_SELECT: cmd.select = 1'b1;
                  ACT_DEFINE: cmd.define = 1'b1;
                  default:    cmd.select = 1'b0;
               endcase
            end
         end
         ST_READ: state_in = ST_CHECK;
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.found ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== sv/led_seq_dp.sv =====
// ----------------------------------------------------------------------------
// led_seq_dp
// mode state, pattern rows, hold counter and result register
// ----------------------------------------------------------------------------
module led_seq_dp
   import led_seq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic [1:0]        action,
   input  logic [3:0]        mode_number,
   input  logic [23:0]       step_colours,
   input  logic [3:0]        step_count,
   input  logic [3:0]        period_digit,
   output logic [MASK_W-1:0] led_mask,
   output logic [2:0]        active_mode,
   output logic [1:0]        reply
);

   logic [MODE_W-1:0] cm_ff, cm_in;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [MASK_W-1:0] shown_ff, shown_in;
   logic [MODE_W-1:0] slot_ff, slot_in;
   logic [STEP_W-1:0] step_ff [MODE_COUNT];
   logic [STEP_W-1:0] step_in [MODE_COUNT];
   logic [HOLD_W-1:0] period_ff [MODE_COUNT];
   logic [HOLD_W-1:0] period_in [MODE_COUNT];
   logic              written_ff [MODE_COUNT];
   logic              written_in [MODE_COUNT];
   logic [1:0]        reply_ff, reply_in;

   logic [MASK_W-1:0] rsp_mask_ff;
   logic [2:0]        rsp_mode_ff;
   logic [1:0]        rsp_reply_ff;

   logic [ROW_W-1:0]   ram_q, row, new_row;
   logic [ENTRY_W-1:0] ent [STEPS_PER_MODE];
   logic [ENTRY_W-1:0] cur_e, zero_e;
   logic [MODE_W-1:0]  cm_next, slot_next;
   logic [STEP_W-1:0]  step_cur, step_next;
   logic [4:0]         count_c;
   logic [3:0]         digit_c;
   logic [HOLD_W-1:0]  new_period;
   logic               mode_ok;

   led_seq_ram #(
      .WIDTH(ROW_W),
      .DEPTH(MODE_COUNT)
   ) u_rows (
      .clock  (clock),
      .wr_en  (cmd.define),
      .wr_addr(slot_ff),
      .wr_data(new_row),
      .rd_addr(cm_ff),
      .rd_data(ram_q)
   );

   assign row    = written_ff[cm_ff] ? ram_q : init_row(cm_ff);
   assign cur_e  = ent[step_cur];
   assign zero_e = ent[0];

   always_comb begin
      for (int s = 0; s < STEPS_PER_MODE; s++) begin
         ent[s] = row[s*ENTRY_W +: ENTRY_W];
      end
   end

   assign step_cur  = step_ff[cm_ff];
   assign step_next = (step_cur == STEP_W'(STEPS_PER_MODE - 1)) ? '0 : step_cur + 1'b1;
   assign cm_next   = (cm_ff == MODE_W'(MODE_COUNT - 1)) ? '0 : cm_ff + 1'b1;
   assign slot_next = (slot_ff == MODE_W'(MODE_COUNT - 1)) ? MODE_W'(FIRST_SLOT)
                                                           : slot_ff + 1'b1;
   assign mode_ok   = ({1'b0, mode_number} < 5'(MODE_COUNT));

   // define clamps
   always_comb begin
      count_c = {1'b0, step_count};
      if (count_c > 5'(MAX_DEFINE_STEPS)) begin
         count_c = 5'(MAX_DEFINE_STEPS);
      end
      if (count_c > 5'(STEPS_PER_MODE)) begin
         count_c = 5'(STEPS_PER_MODE);
      end
      digit_c = (period_digit > 4'(MAX_DIGIT)) ? 4'(MAX_DIGIT) : period_digit;
      new_period = (HOLD_W'(digit_c) + 1'b1) * HOLD_W'(PERIOD_UNIT);
      for (int s = 0; s < STEPS_PER_MODE; s++) begin
         new_row[s*ENTRY_W +: ENTRY_W] = (5'(s) < count_c)
            ? {1'b1, 3'(step_colours >> (3 * s))} : '0;
      end
   end

   always_comb begin
      cm_in      = cm_ff;
      hold_in    = hold_ff;
      shown_in   = shown_ff;
      slot_in    = slot_ff;
      reply_in   = reply_ff;
      step_in    = step_ff;
      period_in  = period_ff;
      written_in = written_ff;

      if (cmd.accept) begin
         reply_in = REPLY_NONE;
      end
      if (cmd.tick_dec) begin
         hold_in = hold_ff - 1'b1;
      end
      if (cmd.tick_adv) begin
         step_in[cm_ff] = step_next;
      end
      if (cmd.next_mode) begin
         cm_in = cm_next;
      end
      if (cmd.select) begin
         if (mode_ok) begin
            cm_in    = MODE_W'(mode_number);
            reply_in = REPLY_OK;
         end else begin
            reply_in = REPLY_REJECT;
         end
      end
      if (cmd.define) begin
         written_in[slot_ff] = 1'b1;
         period_in[slot_ff]  = new_period;
         slot_in             = slot_next;
         reply_in            = REPLY_OK;
      end
      // mode walk over empty steps and empty modes
      if (cmd.check) begin
         if (cur_e[ENTRY_W-1]) begin
            shown_in = cur_e[MASK_W-1:0];
            hold_in  = period_ff[cm_ff];
         end else begin
            step_in[cm_ff] = '0;
            if (zero_e[ENTRY_W-1]) begin
               shown_in = zero_e[MASK_W-1:0];
               hold_in  = period_ff[cm_ff];
            end else begin
               // a mode reached by the walk starts from step 0
               step_in[cm_next] = '0;
               cm_in            = cm_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cm_ff    <= '0;
         hold_ff  <= HOLD_W'(RESET_HOLD);
         shown_ff <= RESET_MASK;
         slot_ff  <= MODE_W'(FIRST_SLOT);
         reply_ff <= REPLY_NONE;
         for (int m = 0; m < MODE_COUNT; m++) begin
            step_ff[m]    <= '0;
            period_ff[m]  <= init_period(m);
            written_ff[m] <= 1'b0;
         end
      end else begin
         cm_ff      <= cm_in;
         hold_ff    <= hold_in;
         shown_ff   <= shown_in;
         slot_ff    <= slot_in;
         reply_ff   <= reply_in;
         step_ff    <= step_in;
         period_ff  <= period_in;
         written_ff <= written_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_mask_ff  <= shown_ff;
         rsp_mode_ff  <= 3'(cm_ff);
         rsp_reply_ff <= reply_ff;
      end
   end

   assign stat.action = action_type'(action);
   assign stat.expire = (hold_ff <= HOLD_W'(1));
   assign stat.found  = cur_e[ENTRY_W-1] | zero_e[ENTRY_W-1];

   assign led_mask    = rsp_mask_ff;
   assign active_mode = rsp_mode_ff;
   assign reply       = rsp_reply_ff;

endmodule

// ===== sv/led_pattern_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// led_pattern_sequencer_top
// three-led pattern sequencer over a table of modes with per-mode hold periods
//
//   channel | dir | tdata                               | tuser
//   req     | in  | mode_number, step_colours,          | action
//           |     | step_count, period_digit            |
//   rsp     | out | led_mask, active_mode               | reply
//
// one word at a time: select, define and a tick that does not expire go from
// idle to finish; an expiry or button press repeats read and check for each
// mode tried, then finishes, paced by the registered read of the row memory.
// synchronous reset restores the built-in patterns; no clearing pass.
// a new word is taken while an earlier result still waits in the output
// register; a stalled result holds the block only at the next handoff.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_top
   import led_seq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // mode_number, step_colours, step_count, period_digit
   input  logic [1:0]  req_tuser,  // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // led_mask, active_mode
   output logic [1:0]  rsp_tuser   // reply
);

   cmd_type           cmd;
   stat_type          stat;
   logic [MASK_W-1:0] led_mask;
   logic [2:0]        active_mode;

   led_seq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .cmd       (cmd),
      .stat      (stat)
   );

   led_seq_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .action      (req_tuser),
      .mode_number (req_tdata[3:0]),
      .step_colours(req_tdata[27:4]),
      .step_count  (req_tdata[31:28]),
      .period_digit(req_tdata[35:32]),
      .led_mask    (led_mask),
      .active_mode (active_mode),
      .reply       (rsp_tuser)
   );

   assign rsp_tdata = {2'b00, active_mode, led_mask};

   // one word in flight
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second word taken before the first finished");

   assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid))
      else $error("controller left idle without a word");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised while idle");

endmodule

// ===== test/tb_led_pattern_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// tb_led_pattern_sequencer_top
// stream-level test of the led pattern sequencer: a directed table of words
// (rejected selects, mode walks, defines with clamped fields, slot wrap) and
// then random bursts of commands followed by long tick runs, every response
// checked against an in-bench model of the mode table, step pointers and
// hold timer, with random stalls on both channels
// ----------------------------------------------------------------------------
module tb_led_pattern_sequencer_top;
   import led_seq_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_WORDS = 1950;
   localparam int QUIET_FIRST  = 700;
   localparam int QUIET_LAST   = 1000;

   typedef struct packed {
      action_type  act;
      logic [3:0]  mode_num;
      logic [23:0] colours;
      logic [3:0]  count;
      logic [3:0]  digit;
      logic        typed;
      logic [2:0]  exp_mask;
      logic [2:0]  exp_mode;
      reply_type   exp_reply;
   } led_cmd_type;

   typedef struct packed {
      logic [2:0] mask;
      logic [2:0] mode;
      reply_type  reply;
   } led_view_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;  // mode_number, step_colours, step_count, period_digit
   logic [1:0]  req_tuser = '0;  // action
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;       // led_mask, active_mode
   logic [1:0]  rsp_tuser;       // reply

   // model state
   logic [3:0] led_table [8][8];
   logic [9:0] period_of [8];
   logic [2:0] step_ptr [8];
   logic [2:0] model_mode;
   logic [9:0] hold_count;
   logic [2:0] lit_mask;
   logic [2:0] define_slot;

   led_view_type pending_views [$];
   led_cmd_type  directed_words [$];
   int           errors = 0;
   int           sent = 0;
   bit           quiet = 1'b0;

   led_pattern_sequencer_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #10 clock = ~clock;

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic void load_power_up();
      logic [2:0] init_pat [4][4];
      init_pat = '{'{3'h1, 3'h2, 3'h1, 3'h2}, '{3'h3, 3'h0, 3'h3, 3'h0},
                   '{3'h1, 3'h2, 3'h4, 3'h0}, '{3'h2, 3'h4, 3'h2, 3'h4}};
      for (int m = 0; m < 8; m++) begin
         for (int s = 0; s < 8; s++) begin
            led_table[m][s] = (m < 4 && s < 4) ? {1'b1, init_pat[m][s]} : 4'h0;
         end
         step_ptr[m] = '0;
      end
      period_of = '{10'd400, 10'd400, 10'd1000, 10'd100,
                    10'd500, 10'd500, 10'd500, 10'd500};
      model_mode  = '0;
      hold_count  = 10'd400;
      lit_mask    = 3'h1;
      define_slot = 3'd4;
   endfunction

   // empty step restarts the mode, empty mode passes on to the next one
   function automatic void show_step();
      logic [3:0] entry;
      bit         found;
      entry = led_table[model_mode][step_ptr[model_mode]];
      if (!entry[3]) begin
         found = 1'b0;
         for (int g = 0; g <= 8; g++) begin
            if (!found) begin
               step_ptr[model_mode] = '0;
               entry = led_table[model_mode][0];
               if (entry[3]) begin
                  found = 1'b1;
               end else begin
                  model_mode = model_mode + 3'd1;
               end
            end
         end
      end
      lit_mask   = entry[2:0];
      hold_count = period_of[model_mode];
   endfunction

   function automatic led_view_type advance_sequencer(led_cmd_type w);
      led_view_type v;
      int           n;
      int           d;
      v.reply = REPLY_NONE;
      case (w.act)
         ACT_TICK: begin
            if (hold_count <= 10'd1) begin
               step_ptr[model_mode] = step_ptr[model_mode] + 3'd1;
               show_step();
            end else begin
               hold_count = hold_count - 10'd1;
            end
         end
         ACT_BUTTON: begin
            model_mode = model_mode + 3'd1;
            show_step();
         end
         ACT_SELECT: begin
            if (w.mode_num >= 4'd8) begin
               v.reply = REPLY_REJECT;
            end else begin
               model_mode = w.mode_num[2:0];
               v.reply    = REPLY_OK;
            end
         end
         default: begin
            n = (w.count > 4'd8) ? 8 : int'(w.count);
            d = (w.digit > 4'd9) ? 9 : int'(w.digit);
            for (int s = 0; s < 8; s++) begin
               led_table[define_slot][s] = (s < n) ? {1'b1, w.colours[3*s +: 3]} : 4'h0;
            end
            period_of[define_slot] = 10'((d + 1) * 100);
            define_slot = (define_slot == 3'd7) ? 3'd4 : define_slot + 3'd1;
            v.reply = REPLY_OK;
         end
      endcase
      v.mask = lit_mask;
      v.mode = model_mode;
      return v;
   endfunction

   function automatic led_cmd_type make_word(action_type a, logic [3:0] m, logic [23:0] c,
                                             logic [3:0] n, logic [3:0] d, logic k,
                                             logic [2:0] em, logic [2:0] ea, reply_type er);
      led_cmd_type w;
      w.act       = a;
      w.mode_num  = m;
      w.colours   = c;
      w.count     = n;
      w.digit     = d;
      w.typed     = k;
      w.exp_mask  = em;
      w.exp_mode  = ea;
      w.exp_reply = er;
      return w;
   endfunction

   function automatic led_cmd_type random_word(action_type a);
      led_cmd_type w;
      w = make_word(a, 4'($urandom_range(0, 15)), 24'($urandom),
                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    1'b0, '0, '0, REPLY_NONE);
      if (a == ACT_SELECT && $urandom_range(0, 99) < 82) begin
         w.mode_num = 4'($urandom_range(0, 7));
      end
      if (a == ACT_DEFINE && $urandom_range(0, 99) < 70) begin
         w.digit = 4'd0;
      end
      return w;
   endfunction

   task automatic send_word(led_cmd_type w);
      led_view_type v;
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 21) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, w.digit, w.count, w.colours, w.mode_num};
      req_tuser  <= w.act;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      v = advance_sequencer(w);
      if (w.typed) begin
         v.mask  = w.exp_mask;
         v.mode  = w.exp_mode;
         v.reply = w.exp_reply;
      end
      pending_views.push_back(v);
      sent++;
      quiet = (sent >= QUIET_FIRST && sent < QUIET_LAST);
   endtask

   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 21);
   end

   always @(posedge clock) begin
      led_view_type v;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_views.size() == 0) begin
            $error("unexpected word: led_mask %0d active_mode %0d reply %0d",
                   rsp_tdata[2:0], rsp_tdata[5:3], rsp_tuser);
            errors++;
         end else begin
            v = pending_views.pop_front();
            if (rsp_tdata[2:0] !== v.mask) begin
               $error("led_mask: expected %0d, got %0d", v.mask, rsp_tdata[2:0]);
               errors++;
            end
            if (rsp_tdata[5:3] !== v.mode) begin
               $error("active_mode: expected %0d, got %0d", v.mode, rsp_tdata[5:3]);
               errors++;
            end
            if (rsp_tuser !== v.reply) begin
               $error("reply: expected %0d, got %0d", v.reply, rsp_tuser);
               errors++;
            end
         end
      end
   end

   initial begin
      int burst;
      int r;
      load_power_up();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_words.push_back(make_word(ACT_TICK,   4'd0,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h1, 3'd0, REPLY_NONE));
      directed_words.push_back(make_word(ACT_SELECT, 4'd9,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h1, 3'd0, REPLY_REJECT));
      directed_words.push_back(make_word(ACT_SELECT, 4'd15, 24'hFFFFFF, 4'd15, 4'd15,
                                         1'b1, 3'h1, 3'd0, REPLY_REJECT));
      directed_words.push_back(make_word(ACT_SELECT, 4'd8,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h1, 3'd0, REPLY_REJECT));
      directed_words.push_back(make_word(ACT_SELECT, 4'd0,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h1, 3'd0, REPLY_OK));
      directed_words.push_back(make_word(ACT_BUTTON, 4'd0,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h3, 3'd1, REPLY_NONE));
      directed_words.push_back(make_word(ACT_BUTTON, 4'd0,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h1, 3'd2, REPLY_NONE));
      directed_words.push_back(make_word(ACT_BUTTON, 4'd0,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h2, 3'd3, REPLY_NONE));
      // empty modes 4..7 are passed over back to mode 0
      directed_words.push_back(make_word(ACT_BUTTON, 4'd0,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h1, 3'd0, REPLY_NONE));
      directed_words.push_back(make_word(ACT_DEFINE, 4'd0,  24'hFFFFFF, 4'd0,  4'd0,
                                         1'b1, 3'h1, 3'd0, REPLY_OK));
      directed_words.push_back(make_word(ACT_DEFINE, 4'd0,  24'hFAC688, 4'd8,  4'd15,
                                         1'b1, 3'h1, 3'd0, REPLY_OK));
      directed_words.push_back(make_word(ACT_DEFINE, 4'd0,  24'h053977, 4'd15, 4'd9,
                                         1'b1, 3'h1, 3'd0, REPLY_OK));
      directed_words.push_back(make_word(ACT_DEFINE, 4'd0,  24'h00002C, 4'd2,  4'd0,
                                         1'b1, 3'h1, 3'd0, REPLY_OK));
      // slot wraps back to 4
      directed_words.push_back(make_word(ACT_DEFINE, 4'd0,  24'h000007, 4'd1,  4'd0,
                                         1'b1, 3'h1, 3'd0, REPLY_OK));
      directed_words.push_back(make_word(ACT_SELECT, 4'd3,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h1, 3'd3, REPLY_OK));
      directed_words.push_back(make_word(ACT_BUTTON, 4'd0,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h7, 3'd4, REPLY_NONE));
      // select keeps the shown mask
      directed_words.push_back(make_word(ACT_SELECT, 4'd2,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h7, 3'd2, REPLY_OK));
      directed_words.push_back(make_word(ACT_SELECT, 4'd5,  24'h0,      4'd0,  4'd0,
                                         1'b1, 3'h7, 3'd5, REPLY_OK));
      // define into the active mode
      directed_words.push_back(make_word(ACT_DEFINE, 4'd0,  24'h000C53, 4'd4,  4'd0,
                                         1'b0, '0, '0, REPLY_NONE));
      directed_words.push_back(make_word(ACT_BUTTON, 4'd0,  24'h0,      4'd0,  4'd0,
                                         1'b0, '0, '0, REPLY_NONE));
      directed_words.push_back(make_word(ACT_TICK,   4'd15, 24'hFFFFFF, 4'd15, 4'd15,
                                         1'b0, '0, '0, REPLY_NONE));
      directed_words.push_back(make_word(ACT_BUTTON, 4'd15, 24'hFFFFFF, 4'd15, 4'd15,
                                         1'b0, '0, '0, REPLY_NONE));
      directed_words.push_back(make_word(ACT_TICK,   4'd0,  24'h0,      4'd0,  4'd0,
                                         1'b0, '0, '0, REPLY_NONE));

      foreach (directed_words[i]) begin
         send_word(directed_words[i]);
      end

      // commands in short bursts, then long tick runs so holds expire
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, 4);
         repeat (burst) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
               send_word(random_word(ACT_BUTTON));
            end else if (r < 70) begin
               send_word(random_word(ACT_SELECT));
            end else begin
               send_word(random_word(ACT_DEFINE));
            end
         end
         burst = $urandom_range(20, 260);
         repeat (burst) begin
            if (sent < RANDOM_WORDS) begin
               send_word(random_word(ACT_TICK));
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_views.size() != 0) begin
         @(posedge clock);
      end
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
